[hdl/pitch_track_note_segmenter_defines.svh]
// Assertion macros used by the checker file.
`ifndef PITCH_TRACK_NOTE_SEGMENTER_DEFINES_SVH
`define PITCH_TRACK_NOTE_SEGMENTER_DEFINES_SVH

// The consequent must hold on the cycle after the antecedent.
`define PTNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define PTNS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[hdl/ptns_pkg.sv]
`default_nettype none
package ptns_pkg;
  localparam int PITCH_W        = 15;
  localparam int WINDOW_MAX_DEF = 128;
  localparam int FRAME_BITS_DEF = 24;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 15;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEADINESS_LIMIT = 2'd2;

  localparam logic [7:0]         WINDOW_FRAMES_RST    = 8'd86;
  localparam logic [PITCH_W-1:0] BOUNDARY_STEP_RST    = 15'd128;
  localparam logic [7:0]         STEADINESS_LIMIT_RST = 8'd26;
endpackage
`default_nettype wire

[hdl/ptns_pitch_if.sv]
`default_nettype none
interface ptns_pitch_if;
  logic                          valid;
  logic                          ready;
  logic [ptns_pkg::PITCH_W-1:0]  pitch;
  logic                          last;
  modport source (output valid, pitch, last, input ready);
  modport sink (input valid, pitch, last, output ready);
endinterface
`default_nettype wire

[hdl/ptns_res_if.sv]
`default_nettype none
interface ptns_res_if #(
  parameter int FrameBits = ptns_pkg::FRAME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [FrameBits-1:0] boundary_frame;
  logic                 final_res;
  modport source (output valid, boundary_frame, final_res, input ready);
  modport sink (input valid, boundary_frame, final_res, output ready);
endinterface
`default_nettype wire

[hdl/pitch_track_note_segmenter.sv]
// For an item that judges a window of N frames, the median is found one bit per pass over the
// window memory (15 passes), then one pass sums the squares of the deviations from it. The
// block takes one item at a time; the next request is taken once the last result is accepted.
// Reset clears registers to their defaults and the frame state; the window memory is not cleared.
`default_nettype none
module pitch_track_note_segmenter #(
  parameter int WindowMax = ptns_pkg::WINDOW_MAX_DEF,
  parameter int FrameBits = ptns_pkg::FRAME_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [ptns_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [ptns_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  ptns_pitch_if.sink                        in_i,
  ptns_res_if.source                        out_o
);
  localparam int PW  = ptns_pkg::PITCH_W;
  localparam int AW  = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int NB  = $clog2(WindowMax + 1);
  localparam int XW  = 34;
  localparam int LW  = 8 + NB;
  localparam int L2W = 2 * LW;
  localparam int SW  = 2 * PW + NB;
  localparam int CW  = (SW > L2W) ? SW : L2W;
  localparam logic [FrameBits-1:0] FRAME_MAX = {FrameBits{1'b1}};

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SEL  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_CMP  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]    wf_q;
  logic [PW-1:0] step_q;
  logic [7:0]    sl_q;

  logic [FrameBits-1:0] fc_q, fc_d, ref_frame_q, ref_frame_d, start_q, start_d;
  logic [FrameBits-1:0] bnd_q, bnd_d, final_q, final_d;
  logic [AW-1:0]        slot_q, slot_d, rd_addr_q, rd_addr_d, rd_start_q, rd_start_d;
  logic [PW-1:0]        ref_med_q, ref_med_d, pitch_q, pitch_d, prefix_q, prefix_d;
  logic [PW-1:0]        rdata_q;
  logic                 last_q, last_d;
  logic [NB-1:0]        n_q, n_d, idx_q, idx_d, kk_q, kk_d, cnt_q, cnt_d;
  logic [LW-1:0]        lim_q, lim_d;
  logic [3:0]           bit_q, bit_d;
  logic                 rv_q, rv_d, sqv_q, sqv_d;
  logic [2*PW-1:0]      sq_q, sq_d;
  logic [SW-1:0]        sum_q, sum_d;
  logic                 pend_first_q, pend_first_d, pend_bnd_q, pend_bnd_d;
  logic                 pend_last_q, pend_last_d;
  logic                 out_valid_q, out_valid_d, out_final_q, out_final_d;
  logic [FrameBits-1:0] out_frame_q, out_frame_d;

  logic                 rd_en, wr_en;
  logic [PW-1:0]        mem_q [WindowMax];

  logic [NB-1:0]        n_eff;
  logic [PW:0]          hmask;
  logic                 match;
  logic [PW-1:0]        dev;
  logic                 judge;
  logic [XW-1:0]        slot_ext, n_ext;
  logic [CW-1:0]        lim_sq, sum_ext;
  logic                 slot_free;

  always_comb begin
    if (wf_q == 8'd0) begin
      n_eff = NB'(1);
    end else if (XW'(wf_q) > XW'(WindowMax)) begin
      n_eff = NB'(WindowMax);
    end else begin
      n_eff = NB'(wf_q);
    end
  end

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.boundary_frame = out_frame_q;
  assign out_o.final_res      = out_final_q;

  assign hmask   = {(PW+1){1'b1}} << ({1'b0, bit_q} + 5'd1);
  assign match   = (((rdata_q ^ prefix_q) & hmask[PW-1:0]) == '0) && !rdata_q[bit_q];
  assign dev     = (rdata_q >= prefix_q) ? (rdata_q - prefix_q) : (prefix_q - rdata_q);
  assign judge   = (fc_q != FRAME_MAX) && (XW'(fc_q) >= (XW'(n_eff) << 1));
  assign slot_ext = XW'(slot_q);
  assign n_ext    = XW'(n_eff);
  assign lim_sq   = CW'(lim_q * lim_q);
  assign sum_ext  = CW'(sum_q);
  assign slot_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wf_q   <= ptns_pkg::WINDOW_FRAMES_RST;
      step_q <= ptns_pkg::BOUNDARY_STEP_RST;
      sl_q   <= ptns_pkg::STEADINESS_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptns_pkg::REG_WINDOW_FRAMES:    wf_q   <= cfg_wdata_i[7:0];
        ptns_pkg::REG_BOUNDARY_STEP:    step_q <= cfg_wdata_i[PW-1:0];
        ptns_pkg::REG_STEADINESS_LIMIT: sl_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    fc_d         = fc_q;
    slot_d       = slot_q;
    ref_frame_d  = ref_frame_q;
    ref_med_d    = ref_med_q;
    start_d      = start_q;
    bnd_d        = bnd_q;
    final_d      = final_q;
    rd_addr_d    = rd_addr_q;
    rd_start_d   = rd_start_q;
    pitch_d      = pitch_q;
    last_d       = last_q;
    prefix_d     = prefix_q;
    n_d          = n_q;
    idx_d        = idx_q;
    kk_d         = kk_q;
    cnt_d        = cnt_q;
    lim_d        = lim_q;
    bit_d        = bit_q;
    rv_d         = 1'b0;
    sqv_d        = 1'b0;
    sq_d         = sq_q;
    sum_d        = sum_q;
    pend_first_d = pend_first_q;
    pend_bnd_d   = pend_bnd_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q;
    out_frame_d  = out_frame_q;
    out_final_d  = out_final_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          pitch_d      = in_i.pitch;
          last_d       = in_i.last;
          n_d          = n_eff;
          lim_d        = LW'(sl_q * n_eff);
          pend_first_d = (fc_q == '0);
          pend_bnd_d   = 1'b0;
          pend_last_d  = 1'b0;
          start_d      = fc_q - FrameBits'(n_eff);
          if (slot_ext >= n_ext) begin
            rd_start_d = AW'(slot_ext - n_ext);
          end else begin
            rd_start_d = AW'(slot_ext + XW'(WindowMax) - n_ext);
          end
          rd_addr_d = rd_start_d;
          idx_d     = '0;
          cnt_d     = '0;
          bit_d     = 4'(PW - 1);
          prefix_d  = '0;
          kk_d      = n_eff >> 1;
          state_d   = judge ? ST_SEL : ST_FIN;
        end
      end
      ST_SEL, ST_SUM: begin
        if (idx_q != n_q) begin
          rd_en = 1'b1;
          rv_d  = 1'b1;
          idx_d = idx_q + NB'(1);
          rd_addr_d = (XW'(rd_addr_q) == XW'(WindowMax - 1)) ? '0 : rd_addr_q + AW'(1);
        end
        if (state_q == ST_SEL) begin
          if (rv_q && match) begin
            cnt_d = cnt_q + NB'(1);
          end
          if (idx_q == n_q && !rv_q) begin
            // Count of smaller candidates decides this bit of the median.
            if (kk_q >= cnt_q) begin
              kk_d            = kk_q - cnt_q;
              prefix_d[bit_q] = 1'b1;
            end
            cnt_d     = '0;
            idx_d     = '0;
            rd_addr_d = rd_start_q;
            sum_d     = '0;
            if (bit_q == 4'd0) begin
              state_d = ST_SUM;
            end else begin
              bit_d = bit_q - 4'd1;
            end
          end
        end else begin
          if (rv_q) begin
            sq_d  = dev * dev;
            sqv_d = 1'b1;
          end
          if (sqv_q) begin
            sum_d = sum_q + SW'(sq_q);
          end
          if (idx_q == n_q && !rv_q && !sqv_q) begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if ((sum_ext < lim_sq) &&
            (((prefix_q > ref_med_q) ? (prefix_q - ref_med_q) : (ref_med_q - prefix_q))
             > step_q)) begin
          pend_bnd_d  = (XW'(start_q) > (XW'(ref_frame_q) + XW'(n_q)));
          bnd_d       = start_q;
          ref_frame_d = start_q;
          ref_med_d   = prefix_q;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        final_d = fc_q;
        if (fc_q != FRAME_MAX) begin
          wr_en   = 1'b1;
          fc_d    = fc_q + FrameBits'(1);
          final_d = fc_d;
          slot_d  = (XW'(slot_q) == XW'(WindowMax - 1)) ? '0 : slot_q + AW'(1);
        end
        if (last_q) begin
          pend_last_d = 1'b1;
          fc_d        = '0;
          slot_d      = '0;
          ref_frame_d = '0;
          ref_med_d   = '0;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (pend_first_q) begin
            pend_first_d = 1'b0;
            out_valid_d  = 1'b1;
            out_frame_d  = '0;
            out_final_d  = 1'b0;
          end else if (pend_bnd_q) begin
            pend_bnd_d  = 1'b0;
            out_valid_d = 1'b1;
            out_frame_d = bnd_q;
            out_final_d = 1'b0;
          end else if (pend_last_q) begin
            pend_last_d = 1'b0;
            out_valid_d = 1'b1;
            out_frame_d = final_q;
            out_final_d = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fc_q         <= '0;
      slot_q       <= '0;
      ref_frame_q  <= '0;
      ref_med_q    <= '0;
      rv_q         <= 1'b0;
      sqv_q        <= 1'b0;
      pend_first_q <= 1'b0;
      pend_bnd_q   <= 1'b0;
      pend_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fc_q         <= fc_d;
      slot_q       <= slot_d;
      ref_frame_q  <= ref_frame_d;
      ref_med_q    <= ref_med_d;
      rv_q         <= rv_d;
      sqv_q        <= sqv_d;
      pend_first_q <= pend_first_d;
      pend_bnd_q   <= pend_bnd_d;
      pend_last_q  <= pend_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    bnd_q       <= bnd_d;
    final_q     <= final_d;
    rd_addr_q   <= rd_addr_d;
    rd_start_q  <= rd_start_d;
    pitch_q     <= pitch_d;
    last_q      <= last_d;
    prefix_q    <= prefix_d;
    n_q         <= n_d;
    idx_q       <= idx_d;
    kk_q        <= kk_d;
    cnt_q       <= cnt_d;
    lim_q       <= lim_d;
    bit_q       <= bit_d;
    sq_q        <= sq_d;
    sum_q       <= sum_d;
    out_frame_q <= out_frame_d;
    out_final_q <= out_final_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[slot_q] <= pitch_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr_q];
    end
  end
endmodule
`default_nettype wire

[hdl/ptns_checker.sv]
`default_nettype none
`include "pitch_track_note_segmenter_defines.svh"
module ptns_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire out_final_i
);
  `PTNS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  // The block works on one request at a time.
  `PTNS_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // The closing entry is the last result of its request.
  `PTNS_ASSERT_NEXT(a_final_ends, clk_i, rst_ni, out_valid_i && out_ready_i && out_final_i,
    !out_valid_i)
  // While a new request can be taken, no result is left waiting.
  `PTNS_ASSERT_NOW(a_idle_empty, clk_i, rst_ni, in_ready_i, !out_valid_i)
endmodule

bind pitch_track_note_segmenter ptns_checker u_ptns_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_final_i (out_o.final_res)
);
`default_nettype wire

[bench/pitch_track_note_segmenter_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module pitch_track_note_segmenter_tb;
  localparam int RING = ptns_pkg::WINDOW_MAX_DEF;
  localparam int FB = ptns_pkg::FRAME_BITS_DEF;
  localparam int PW = ptns_pkg::PITCH_W;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [ptns_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [FB-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [PW-1:0] pitch;
    logic          last;
  } frame_t;

  typedef struct packed {
    logic [FB-1:0] frame;
    logic          fin;
  } mark_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [ptns_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [ptns_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ptns_pitch_if pitch_if ();
  ptns_res_if res_if ();

  pitch_track_note_segmenter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (pitch_if),
    .out_o       (res_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  frame_t pending_q[$];
  mark_t  note_marks_q[$];
  int     err_cnt = 0;
  bit     calm = 1'b0;
  bit     hold_req = 1'b0;
  int     idle_cycles = 0;

  // Segmenter state mirrored for prediction.
  logic [7:0]    win_reg;
  logic [PW-1:0] step_reg;
  logic [7:0]    steady_reg;
  logic [PW-1:0] pitch_ring[RING];
  logic [FB-1:0] frames_seen;
  logic [FB-1:0] anchor_frame;
  logic [PW-1:0] anchor_median;

  function automatic int window_len();
    if (win_reg == 0) return 1;
    if (win_reg > RING) return RING;
    return int'(win_reg);
  endfunction

  // Judges one window; updates the anchor and returns 1 for a new note start.
  function automatic bit judge_window(int start, int n);
    int vals[RING];
    int k, j, v, med, d;
    longint sum, lim;
    bit is_start;
    for (k = 0; k < n; k++) vals[k] = int'(pitch_ring[(start + k) % RING]);
    for (k = 1; k < n; k++) begin
      v = vals[k];
      j = k;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    med = vals[n/2];
    sum = 0;
    for (k = 0; k < n; k++) begin
      d = vals[k] - med;
      sum += longint'(d) * d;
    end
    lim = longint'(steady_reg) * n;
    if (!(sum < lim * lim)) return 1'b0;
    d = med - int'(anchor_median);
    if (d < 0) d = -d;
    if (d <= int'(step_reg)) return 1'b0;
    is_start = longint'(start) > longint'(anchor_frame) + n;
    anchor_frame = FB'(start);
    anchor_median = PW'(med);
    return is_start;
  endfunction

  function automatic void predict_marks(frame_t it);
    int n, f;
    n = window_len();
    f = int'(frames_seen);
    if (f == 0) note_marks_q.push_back('{frame: '0, fin: 1'b0});
    if (frames_seen < COUNT_MAX) begin
      if (f >= 2 * n && judge_window(f - n, n))
        note_marks_q.push_back('{frame: FB'(f - n), fin: 1'b0});
      pitch_ring[f % RING] = it.pitch;
      frames_seen = frames_seen + 1'b1;
    end
    if (it.last) begin
      note_marks_q.push_back('{frame: frames_seen, fin: 1'b1});
      frames_seen = '0;
      anchor_frame = '0;
      anchor_median = '0;
    end
  endfunction

  // Sender.
  int src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_if.valid <= 1'b0;
      pitch_if.pitch <= '0;
      pitch_if.last  <= 1'b0;
      src_gap = 0;
    end else begin
      frame_t it;
      if (pitch_if.valid && pitch_if.ready) predict_marks('{pitch_if.pitch, pitch_if.last});
      if (!pitch_if.valid || pitch_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          pitch_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          src_gap = $urandom_range(1, 14) - 1;
          pitch_if.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          it = pending_q.pop_front();
          pitch_if.valid <= 1'b1;
          pitch_if.pitch <= it.pitch;
          pitch_if.last  <= it.last;
        end else begin
          pitch_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  int snk_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      mark_t want;
      if (res_if.valid && res_if.ready) begin
        if (note_marks_q.size() == 0) begin
          $error("unexpected result: boundary_frame %0d final_res %0d",
                 res_if.boundary_frame, res_if.final_res);
          err_cnt++;
        end else begin
          want = note_marks_q.pop_front();
          if (res_if.boundary_frame !== want.frame) begin
            $error("boundary_frame: expected %0d, actual %0d", want.frame,
                   res_if.boundary_frame);
            err_cnt++;
          end
          if (res_if.final_res !== want.fin) begin
            $error("final_res: expected %0d, actual %0d", want.fin, res_if.final_res);
            err_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        snk_gap = 600;
      end
      if (snk_gap > 0) begin
        snk_gap--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        snk_gap = $urandom_range(1, 14) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on forward progress.
  always @(posedge clk_i) begin
    if ((pitch_if.valid && pitch_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("pitch_track_note_segmenter regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [ptns_pkg::CFG_IDX_W-1:0] idx, int value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= ptns_pkg::CFG_DATA_W'(value);
    case (idx)
      ptns_pkg::REG_WINDOW_FRAMES:    win_reg = 8'(value);
      ptns_pkg::REG_BOUNDARY_STEP:    step_reg = PW'(value);
      ptns_pkg::REG_STEADINESS_LIMIT: steady_reg = 8'(value);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Waits for every queued frame and note mark, then lets a window judgment finish.
  task automatic drain();
    int n;
    do @(posedge clk_i);
    while (pending_q.size() != 0 || pitch_if.valid || note_marks_q.size() != 0);
    n = window_len();
    repeat (16 * (n + 1) + n + 40) @(posedge clk_i);
  endtask

  task automatic add_frame(int p, bit l);
    pending_q.push_back('{pitch: PW'(p), last: l});
  endtask

  // Queues held notes with jitter, rests and some noise frames.
  task automatic add_notes(int n, int total, bit close);
    int left, len, lvl, jit, k, p;
    left = total;
    while (left > 0) begin
      len = $urandom_range(n, 4 * n + 4);
      if (len > left) len = left;
      lvl = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32767);
      jit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      for (k = 0; k < len; k++) begin
        p = (lvl == 0) ? 0 : lvl + $urandom_range(0, jit);
        if (p > 32767) p = 32767;
        if ($urandom_range(0, 40) == 0) p = $urandom_range(0, 32767);
        add_frame(p, (close && left == 1) || $urandom_range(0, 299) == 0);
        left--;
      end
    end
  endtask

  initial begin
    int ph, n, sent;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    win_reg    = ptns_pkg::WINDOW_FRAMES_RST;
    step_reg   = ptns_pkg::BOUNDARY_STEP_RST;
    steady_reg = ptns_pkg::STEADINESS_LIMIT_RST;
    frames_seen   = '0;
    anchor_frame  = '0;
    anchor_median = '0;
    for (int k = 0; k < RING; k++) pitch_ring[k] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default registers: a single-frame recording, a three-frame one and pitch extremes.
    add_frame(0, 1'b1);
    add_frame(32767, 1'b0);
    add_frame(0, 1'b0);
    add_frame(32767, 1'b1);
    drain();

    // Window length zero acts as one; a clean note change, then a change too soon.
    write_reg(ptns_pkg::REG_WINDOW_FRAMES, 0);
    write_reg(ptns_pkg::REG_BOUNDARY_STEP, 0);
    write_reg(ptns_pkg::REG_STEADINESS_LIMIT, 255);
    write_reg(REG_UNUSED, 32767);
    for (int k = 0; k < 4; k++) add_frame(100, 1'b0);
    for (int k = 0; k < 4; k++) add_frame(5000, 1'b0);
    add_frame(5001, 1'b0);
    for (int k = 0; k < 4; k++) add_frame(20000, 1'b0);
    add_frame(0, 1'b0);
    add_frame(32767, 1'b1);
    drain();

    for (ph = 0; ph < 14; ph++) begin
      write_reg(ptns_pkg::REG_WINDOW_FRAMES, $urandom_range(1, 8));
      case ($urandom_range(0, 3))
        0: write_reg(ptns_pkg::REG_BOUNDARY_STEP, 0);
        1: write_reg(ptns_pkg::REG_BOUNDARY_STEP, 32767);
        default: write_reg(ptns_pkg::REG_BOUNDARY_STEP, $urandom_range(0, 3000));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(ptns_pkg::REG_STEADINESS_LIMIT, 0);
        1: write_reg(ptns_pkg::REG_STEADINESS_LIMIT, 255);
        default: write_reg(ptns_pkg::REG_STEADINESS_LIMIT, $urandom_range(1, 255));
      endcase
      if (ph == 5) hold_req = 1'b1;
      if (ph == 12) calm = 1'b1;
      n = window_len();
      sent = 0;
      while (sent < 60) begin
        int len;
        len = $urandom_range(4 * n, 12 * n);
        add_notes(n, len, $urandom_range(0, 3) != 0);
        sent += len;
      end
      drain();
      // The longest windows run on one closed batch of notes each.
      if (ph == 3 || ph == 9) begin
        write_reg(ptns_pkg::REG_WINDOW_FRAMES, (ph == 3) ? 128 : 255);
        write_reg(ptns_pkg::REG_STEADINESS_LIMIT, 255);
        write_reg(ptns_pkg::REG_BOUNDARY_STEP, 64);
        add_notes(128, 270, 1'b1);
        drain();
      end
    end

    if (err_cnt == 0 && note_marks_q.size() == 0)
      $display("pitch_track_note_segmenter regression: pass");
    else
      $display("pitch_track_note_segmenter regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
